FILE: rtl/core/slpm_pkg.sv
// ----------------------------------------------------------------------------
// slpm_pkg
// Shared types, codes and the character class function of the step list
// prefix matcher.
// ----------------------------------------------------------------------------
package slpm_pkg;

    // sizes
    localparam int SLPM_MAX_STEPS = 8;
    localparam int NUM_STEP_REGS  = 8;
    localparam int STEP_WORD_W    = 11;
    localparam int CFG_ADDR_W     = 5;
    localparam int CFG_DATA_W     = 32;
    localparam int STEP_IDX_W     = 4;

    // step kinds
    localparam logic [2:0] KIND_END   = 3'd0;
    localparam logic [2:0] KIND_LIT   = 3'd1;
    localparam logic [2:0] KIND_PEEK  = 3'd2;
    localparam logic [2:0] KIND_OPT   = 3'd3;
    localparam logic [2:0] KIND_ANY   = 3'd4;
    localparam logic [2:0] KIND_CLASS = 3'd5;
    localparam logic [2:0] KIND_SKIP  = 3'd6;

    // match status codes
    localparam logic [1:0] ST_UNDECIDED = 2'd0;
    localparam logic [1:0] ST_MATCH     = 2'd1;
    localparam logic [1:0] ST_FAIL      = 2'd2;

    // character class codes
    localparam logic [7:0] CLS_DIGIT  = 8'd0;
    localparam logic [7:0] CLS_ALNUM  = 8'd1;
    localparam logic [7:0] CLS_SPACE  = 8'd2;
    localparam logic [7:0] CLS_CNTRL  = 8'd3;
    localparam logic [7:0] CLS_LOWER  = 8'd4;
    localparam logic [7:0] CLS_GRAPH  = 8'd5;
    localparam logic [7:0] CLS_PRINT  = 8'd6;
    localparam logic [7:0] CLS_PUNCT  = 8'd7;
    localparam logic [7:0] CLS_XDIGIT = 8'd8;
    localparam logic [7:0] CLS_UPPER  = 8'd9;
    localparam logic [7:0] CLS_ALPHA  = 8'd10;

    localparam logic [7:0] NUL_BYTE = 8'h00;

    typedef logic [STEP_WORD_W-1:0] t_step_word;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       string_start;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            match_status;
        logic [STEP_IDX_W-1:0] step_reached;
    } t_out_item;

    // where the token ends inside a cell and with what verdict
    typedef struct packed {
        logic stop;
        logic match;
        logic fail;
    } t_cell_flags;

    // C locale classes, upper half belongs to no class
    function automatic logic in_class(input logic [7:0] cls, input logic [7:0] b);
        logic dig, up, lo, al, graph, hexl;
        logic res;
        dig   = (b >= 8'h30) && (b <= 8'h39);
        up    = (b >= 8'h41) && (b <= 8'h5A);
        lo    = (b >= 8'h61) && (b <= 8'h7A);
        al    = up || lo;
        graph = (b >= 8'h21) && (b <= 8'h7E);
        hexl  = ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
        case (cls)
            CLS_DIGIT:  res = dig;
            CLS_ALNUM:  res = al || dig;
            CLS_SPACE:  res = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
            CLS_CNTRL:  res = (b < 8'h20) || (b == 8'h7F);
            CLS_LOWER:  res = lo;
            CLS_GRAPH:  res = graph;
            CLS_PRINT:  res = (b >= 8'h20) && (b <= 8'h7E);
            CLS_PUNCT:  res = graph && !(al || dig);
            CLS_XDIGIT: res = dig || hexl;
            CLS_UPPER:  res = up;
            CLS_ALPHA:  res = al;
            default:    res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/core/step_list_prefix_matcher_core.sv
// ----------------------------------------------------------------------------
// step_list_prefix_matcher_core
// Anchored prefix matcher over a configured list of steps.
// ----------------------------------------------------------------------------
// While the consumer is ready, the block takes one string byte per clock
// cycle and returns one result per byte: the match status and the step
// reached after that byte. Every byte is resolved in the cycle it is accepted,
// since a one-hot token runs through a row of step cells in which zero-width
// steps pass it on within the cycle; the result then sits in an output
// register. The step words are written over the APB port; the user must
// write them only while no string is in flight, the block does not enforce it.
module step_list_prefix_matcher_core #(
    parameter int MAX_STEPS = slpm_pkg::SLPM_MAX_STEPS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // byte input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  slpm_pkg::t_in_item              i_in_data,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output slpm_pkg::t_out_item             o_out_data,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [slpm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [slpm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [slpm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import slpm_pkg::*;

    localparam int REG_IDX_W = $clog2(NUM_STEP_REGS);

    t_step_word             r_step [NUM_STEP_REGS];
    logic [MAX_STEPS:0]     r_active;
    logic [1:0]             r_status;
    logic                   r_out_valid;
    t_out_item              r_out_data;

    logic [MAX_STEPS:0]     n_active;
    logic [1:0]             n_status;
    t_out_item              n_out_data;

    logic                   w_in_fire;
    logic                   w_cfg_wr;
    logic [REG_IDX_W-1:0]   w_reg_idx;
    logic [MAX_STEPS:0]     w_start;
    logic [1:0]             w_status;
    logic [MAX_STEPS:0]     w_pass;
    logic [MAX_STEPS:0]     w_cons;
    t_cell_flags            w_flag [MAX_STEPS+1];
    logic [MAX_STEPS:0]     w_stops;
    logic                   w_any_match;
    logic                   w_any_fail;
    logic [STEP_IDX_W-1:0]  w_idx;

    // configuration register file
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[REG_IDX_W+1:2];
    assign w_cfg_wr  = psel & penable & pwrite;
    assign prdata    = CFG_DATA_W'(r_step[w_reg_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_STEP_REGS; k++) begin
                r_step[k] <= '0;
            end
        end else if (w_cfg_wr) begin
            r_step[w_reg_idx] <= pwdata[STEP_WORD_W-1:0];
        end
    end

    // handshake: output register, refilled as it drains
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // starting point for this byte, a new string restarts at step 0
    always_comb begin
        w_start  = r_active;
        w_status = r_status;
        if (i_in_data.string_start) begin
            w_start  = (MAX_STEPS+1)'(1);
            w_status = ST_UNDECIDED;
        end
    end

    // row of step cells
    assign w_pass[0] = 1'b0;
    assign w_cons[0] = 1'b0;

    for (genvar g = 0; g < MAX_STEPS; g++) begin : g_cell
        slpm_cell u_cell (
            .i_word   (r_step[g]),
            .i_byte   (i_in_data.text_byte),
            .i_active (w_start[g]),
            .i_pass   (w_pass[g]),
            .i_cons   (w_cons[g]),
            .o_pass   (w_pass[g+1]),
            .o_cons   (w_cons[g+1]),
            .o_flags  (w_flag[g])
        );
    end

    // running off the list counts as an end step
    always_comb begin
        w_flag[MAX_STEPS].stop  = w_start[MAX_STEPS] | w_pass[MAX_STEPS] | w_cons[MAX_STEPS];
        w_flag[MAX_STEPS].match = w_flag[MAX_STEPS].stop;
        w_flag[MAX_STEPS].fail  = 1'b0;
    end

    // collect where the token stopped and the verdict
    always_comb begin
        w_any_match = 1'b0;
        w_any_fail  = 1'b0;
        for (int k = 0; k <= MAX_STEPS; k++) begin
            w_stops[k]  = w_flag[k].stop;
            w_any_match = w_any_match | w_flag[k].match;
            w_any_fail  = w_any_fail | w_flag[k].fail;
        end
    end

    // next state, a verdict latches until the next string
    always_comb begin
        n_active = w_start;
        n_status = w_status;
        if (w_status == ST_UNDECIDED) begin
            n_active = w_stops;
            if (w_any_match) begin
                n_status = ST_MATCH;
            end else if (w_any_fail || (i_in_data.text_byte == NUL_BYTE)) begin
                n_status = ST_FAIL;
            end
        end
    end

    // one-hot step to index
    always_comb begin
        w_idx = '0;
        for (int k = 0; k <= MAX_STEPS; k++) begin
            if (n_active[k]) begin
                w_idx = w_idx | STEP_IDX_W'(k);
            end
        end
    end

    always_comb begin
        n_out_data.match_status = n_status;
        n_out_data.step_reached = w_idx;
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= (MAX_STEPS+1)'(1);
            r_status    <= ST_UNDECIDED;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_active <= n_active;
                r_status <= n_status;
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

FILE: rtl/core/slpm_cell.sv
// ----------------------------------------------------------------------------
// slpm_cell
// One step of the list: takes the match token from its left neighbor or from
// its own active bit, judges the byte and hands the token to the right.
// ----------------------------------------------------------------------------
module slpm_cell (
    input  slpm_pkg::t_step_word  i_word,
    input  logic [7:0]            i_byte,
    input  logic                  i_active,
    input  logic                  i_pass,
    input  logic                  i_cons,
    output logic                  o_pass,
    output logic                  o_cons,
    output slpm_pkg::t_cell_flags o_flags
);
    import slpm_pkg::*;

    logic [2:0] w_kind;
    logic [7:0] w_opnd;
    logic       w_arr;
    logic       w_eq;
    logic       w_cls;
    logic       w_zero;

    assign w_kind = i_word[10:8];
    assign w_opnd = i_word[7:0];
    assign w_arr  = i_active | i_pass;
    assign w_eq   = (i_byte == w_opnd);
    assign w_cls  = in_class(w_opnd, i_byte);
    assign w_zero = (i_byte == NUL_BYTE);

    // step evaluation
    always_comb begin
        o_pass  = 1'b0;
        o_cons  = 1'b0;
        o_flags = '0;
        if (i_cons) begin
            // byte already used up: stop here, or match on an end step
            o_flags.stop  = 1'b1;
            o_flags.match = (w_kind == KIND_END);
        end else if (w_arr) begin
            case (w_kind)
                KIND_END: begin
                    o_flags.stop  = 1'b1;
                    o_flags.match = 1'b1;
                end
                KIND_LIT: begin
                    o_cons       = w_eq;
                    o_flags.stop = !w_eq;
                    o_flags.fail = !w_eq;
                end
                KIND_PEEK: begin
                    o_pass       = w_eq;
                    o_flags.stop = !w_eq;
                    o_flags.fail = !w_eq;
                end
                KIND_OPT: begin
                    o_cons = w_eq;
                    o_pass = !w_eq;
                end
                KIND_ANY: begin
                    o_cons       = !w_zero;
                    o_flags.stop = w_zero;
                    o_flags.fail = w_zero;
                end
                KIND_CLASS: begin
                    o_cons       = w_cls;
                    o_flags.stop = !w_cls;
                    o_flags.fail = !w_cls;
                end
                KIND_SKIP: begin
                    // out-of-class bytes are eaten and the step stays
                    o_cons       = w_cls;
                    o_flags.stop = !w_cls;
                    o_flags.fail = !w_cls && w_zero;
                end
                default: begin
                    o_flags.stop = 1'b1;
                    o_flags.fail = 1'b1;
                end
            endcase
        end
    end

endmodule

FILE: bench/tb_step_list_prefix_matcher_core.sv
// ----------------------------------------------------------------------------
// tb_step_list_prefix_matcher_core
// Self-checking bench for the step list prefix matcher: programs step lists
// over APB, streams strings byte by byte and checks every match result
// against a cycle-free model of the step walk, with random stalls both ways.
// ----------------------------------------------------------------------------
module tb_step_list_prefix_matcher_core;

    import slpm_pkg::*;

    localparam int         RAND_ITEMS   = 750;
    localparam int         SETTLE_CYC   = 4;
    localparam int         HOLD_CYCLES  = 60;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam logic [2:0] KIND_UNDEF   = 3'd7;
    localparam logic [7:0] CLS_UNUSED   = 8'd11;
    localparam logic [7:0] CLS_FAR      = 8'd200;
    localparam t_step_word WORD_TOP     = 11'd1791;

    // predicts the status of every byte and holds results still to arrive
    class step_match_scoreboard;
        t_step_word words[SLPM_MAX_STEPS];
        logic [3:0] at_step;
        logic [1:0] verdict;
        t_out_item  awaited_q[$];
        int         mismatches;
        int         checked;
        int         n_match;
        int         n_fail;

        function new();
            foreach (words[i]) words[i] = '0;
            at_step    = '0;
            verdict    = ST_UNDECIDED;
            mismatches = 0;
            checked    = 0;
            n_match    = 0;
            n_fail     = 0;
        endfunction

        function void set_step(int idx, t_step_word w);
            words[idx] = w;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        // C locale character classes, nothing above 0x7f
        function bit class_has(logic [7:0] cls, logic [7:0] b);
            bit digit, upper, lower, printable, res;
            digit     = (b >= 8'h30) && (b <= 8'h39);
            upper     = (b >= 8'h41) && (b <= 8'h5A);
            lower     = (b >= 8'h61) && (b <= 8'h7A);
            printable = (b >= 8'h20) && (b < 8'h7F);
            case (cls)
                CLS_DIGIT:  res = digit;
                CLS_ALNUM:  res = digit || upper || lower;
                CLS_SPACE:  res = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
                CLS_CNTRL:  res = (b < 8'h20) || (b == 8'h7F);
                CLS_LOWER:  res = lower;
                CLS_GRAPH:  res = printable && (b != 8'h20);
                CLS_PRINT:  res = printable;
                CLS_PUNCT:  res = printable && (b != 8'h20) && !(digit || upper || lower);
                CLS_XDIGIT: res = digit || ((b >= 8'h41) && (b <= 8'h46))
                                  || ((b >= 8'h61) && (b <= 8'h66));
                CLS_UPPER:  res = upper;
                CLS_ALPHA:  res = upper || lower;
                default:    res = 1'b0;
            endcase
            return res;
        endfunction

        // an end word or the slot past the last step both count as done
        function bit past_list(int s);
            if (s >= SLPM_MAX_STEPS) return 1'b1;
            return words[s][10:8] == KIND_END;
        endfunction

        // walk zero-width steps until one consumes the byte or a verdict falls
        function void consume_byte(logic [7:0] b);
            int         s;
            bit         eaten;
            logic [2:0] kind;
            logic [7:0] opnd;
            s     = at_step;
            eaten = 1'b0;
            for (int g = 0; g <= SLPM_MAX_STEPS + 1; g++) begin
                if (past_list(s)) begin
                    verdict = ST_MATCH;
                    break;
                end
                if (eaten) break;
                kind = words[s][10:8];
                opnd = words[s][7:0];
                case (kind)
                    KIND_LIT: begin
                        if (b != opnd) verdict = ST_FAIL;
                        else begin
                            eaten = 1'b1;
                            s++;
                        end
                    end
                    KIND_PEEK: begin
                        if (b != opnd) verdict = ST_FAIL;
                        else s++;
                    end
                    KIND_OPT: begin
                        if (b == opnd) eaten = 1'b1;
                        s++;
                    end
                    KIND_ANY: begin
                        if (b == NUL_BYTE) verdict = ST_FAIL;
                        else begin
                            eaten = 1'b1;
                            s++;
                        end
                    end
                    KIND_CLASS: begin
                        if (!class_has(opnd, b)) verdict = ST_FAIL;
                        else begin
                            eaten = 1'b1;
                            s++;
                        end
                    end
                    KIND_SKIP: begin
                        eaten = 1'b1;
                        if (class_has(opnd, b)) s++;
                        else if (b == NUL_BYTE) verdict = ST_FAIL;
                    end
                    default: verdict = ST_FAIL;
                endcase
                if (verdict != ST_UNDECIDED) break;
                if (eaten && !past_list(s)) break;
            end
            at_step = 4'(s);
            if (verdict == ST_UNDECIDED && b == NUL_BYTE) verdict = ST_FAIL;
        endfunction

        function void note_byte(t_in_item it);
            t_out_item e;
            if (it.string_start) begin
                at_step = '0;
                verdict = ST_UNDECIDED;
            end
            if (verdict == ST_UNDECIDED) consume_byte(it.text_byte);
            e.match_status = verdict;
            e.step_reached = at_step;
            awaited_q.push_back(e);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (awaited_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d step %0d",
                             got.match_status, got.step_reached);
                return;
            end
            want = awaited_q.pop_front();
            checked++;
            if (want.match_status == ST_MATCH) n_match++;
            if (want.match_status == ST_FAIL) n_fail++;
            if (got.match_status !== want.match_status ||
                got.step_reached !== want.step_reached) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: status exp %0d got %0d, step exp %0d got %0d",
                             checked, want.match_status, got.match_status,
                             want.step_reached, got.step_reached);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    step_match_scoreboard sb;
    t_step_word           prog[SLPM_MAX_STEPS];
    logic [7:0]           text_q[$];
    int                   n_items;
    int                   n_strings;
    int                   n_programs;
    int                   cycle_count = 0;
    bit                   calm        = 1'b0;
    bit                   hold_go     = 1'b0;
    logic                 hold_on     = 1'b0;

    step_list_prefix_matcher_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_step_list_prefix_matcher_core NOT OK");
            $finish;
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // result side: check each transaction, stall in random bursts
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
            if (hold_on) begin
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // apb write: setup cycle, then access cycle until pready
    task automatic write_step(input int idx, input t_step_word w);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * idx);
        pwdata  <= CFG_DATA_W'(w);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_step(idx, w);
    endtask

    // back to back writes, bus released after the last one
    task automatic program_steps();
        for (int i = 0; i < SLPM_MAX_STEPS; i++) write_step(i, prog[i]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_programs++;
    endtask

    // one byte transaction, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic st);
        t_in_item it;
        it.text_byte    = b;
        it.string_start = st;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(it);
        n_items++;
    endtask

    task automatic send_text(input logic lead_start);
        foreach (text_q[i]) send_byte(text_q[i], (i == 0) ? lead_start : 1'b0);
        n_strings++;
    endtask

    // drain all results and let the block settle before touching registers
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function automatic logic [7:0] member_byte(logic [7:0] cls);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        for (int t = 0; t < 300; t++) begin
            if (sb.class_has(cls, b)) return b;
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    function automatic logic [7:0] outside_byte(logic [7:0] cls);
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        for (int t = 0; t < 300; t++) begin
            if (!sb.class_has(cls, b)) return b;
            b = 8'($urandom_range(1, 255));
        end
        return b;
    endfunction

    // step word biased toward lists that real strings can walk through
    function automatic t_step_word rand_word();
        int         r;
        logic [2:0] kind;
        logic [7:0] op;
        r = $urandom_range(0, 99);
        kind = (r < 8)  ? KIND_END  : (r < 28) ? KIND_LIT   : (r < 36) ? KIND_PEEK :
               (r < 48) ? KIND_OPT  : (r < 62) ? KIND_ANY   : (r < 80) ? KIND_CLASS :
               KIND_SKIP;
        if (kind == KIND_CLASS || kind == KIND_SKIP) begin
            if ($urandom_range(0, 9) == 0) op = 8'($urandom_range(11, 255));
            else op = 8'($urandom_range(0, 10));
        end else begin
            r = $urandom_range(0, 9);
            if (r < 4) op = 8'h61 + 8'($urandom_range(0, 25));
            else if (r == 4) op = NUL_BYTE;
            else op = 8'($urandom_range(0, 255));
        end
        return {kind, op};
    endfunction

    // string that follows the programmed steps, else plain noise
    function automatic void build_text();
        int         forced;
        logic [2:0] kind;
        logic [7:0] op;
        logic [7:0] cand[$];
        text_q.delete();
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom_range(0, 255)));
            text_q.push_back(NUL_BYTE);
            return;
        end
        forced = -1;
        for (int s = 0; s < SLPM_MAX_STEPS; s++) begin
            kind = prog[s][10:8];
            op   = prog[s][7:0];
            if (kind == KIND_END) break;
            cand.delete();
            case (kind)
                KIND_LIT:   cand.push_back(op);
                KIND_PEEK:  forced = op;
                KIND_OPT:   if ($urandom_range(0, 1) == 1) cand.push_back(op);
                KIND_ANY:   cand.push_back(8'($urandom_range(1, 255)));
                KIND_CLASS: cand.push_back(member_byte(op));
                KIND_SKIP: begin
                    repeat ($urandom_range(0, 3)) cand.push_back(outside_byte(op));
                    cand.push_back(member_byte(op));
                end
                default:    cand.push_back(8'($urandom_range(0, 255)));
            endcase
            // a peek asks the next consumed byte to be its operand
            foreach (cand[i]) begin
                if (forced >= 0) begin
                    text_q.push_back(8'(forced));
                    forced = -1;
                end else begin
                    text_q.push_back(cand[i]);
                end
            end
        end
        if (forced >= 0) text_q.push_back(8'(forced));
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 9) < 7) text_q.push_back(NUL_BYTE);
        if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
            text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    // stimulus
    initial begin
        int rand_base;
        int phase;
        sb          = new();
        n_items     = 0;
        n_strings   = 0;
        n_programs  = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset list is all end words: bytes match without a string start
        text_q = '{8'h41, 8'hFF};
        send_text(1'b0);

        // every step kind on one string, terminator taken by a literal
        quiesce();
        prog = '{{KIND_LIT, 8'h61}, {KIND_PEEK, 8'h62}, {KIND_OPT, 8'h78},
                 {KIND_ANY, 8'h00}, {KIND_CLASS, CLS_DIGIT}, {KIND_SKIP, CLS_PUNCT},
                 {KIND_LIT, NUL_BYTE}, {KIND_END, 8'h00}};
        program_steps();
        text_q = '{8'h61, 8'h62, 8'h37, 8'h71, 8'h21, NUL_BYTE, NUL_BYTE};
        send_text(1'b1);

        // seven optionals pass a mismatch on to a final any step: running off the end matches
        quiesce();
        prog = '{{KIND_OPT, 8'h7A}, {KIND_OPT, 8'h7A}, {KIND_OPT, 8'h7A},
                 {KIND_OPT, 8'h7A}, {KIND_OPT, 8'h7A}, {KIND_OPT, 8'h7A},
                 {KIND_OPT, 8'h7A}, {KIND_ANY, 8'h00}};
        program_steps();
        text_q = '{8'h6B};
        send_text(1'b1);
        text_q = '{8'hFF};
        send_text(1'b1);
        text_q = '{NUL_BYTE};
        send_text(1'b1);

        // skip to an unknown class runs to the terminator and fails
        quiesce();
        prog = '{{KIND_SKIP, CLS_FAR}, '0, '0, '0, '0, '0, '0, '0};
        program_steps();
        text_q = '{8'h61, 8'h62, NUL_BYTE};
        send_text(1'b1);

        // class step with an unknown class code fails
        quiesce();
        prog = '{{KIND_OPT, 8'h6D}, {KIND_CLASS, CLS_UNUSED}, '0, '0, '0, '0, '0, '0};
        program_steps();
        text_q = '{8'h6D, 8'h6D};
        send_text(1'b1);

        // undefined kind fails on the first byte
        quiesce();
        prog = '{{KIND_UNDEF, 8'h00}, '0, '0, '0, '0, '0, '0, '0};
        program_steps();
        text_q = '{8'h78};
        send_text(1'b1);

        // random step lists, extremes first
        rand_base = n_items;
        phase     = 0;
        while (n_items - rand_base < RAND_ITEMS) begin
            quiesce();
            foreach (prog[i]) begin
                case (phase)
                    0:       prog[i] = WORD_TOP;
                    1:       prog[i] = '0;
                    2:       prog[i] = (i % 2 == 0) ? WORD_TOP : rand_word();
                    default: prog[i] = rand_word();
                endcase
            end
            program_steps();
            if (!hold_go && n_items - rand_base > 300) hold_go = 1'b1;
            repeat ($urandom_range(3, 8)) begin
                if (n_items - rand_base >= RAND_ITEMS * 85 / 100) calm = 1'b1;
                build_text();
                send_text($urandom_range(0, 11) != 0);
            end
            phase++;
        end

        quiesce();
        $display("covered %0d bytes in %0d strings over %0d step lists",
                 n_items, n_strings, n_programs);
        $display("%0d results checked: %0d matched, %0d failed, %0d mismatches",
                 sb.checked, sb.n_match, sb.n_fail, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_step_list_prefix_matcher_core OK");
        end else begin
            $display("tb_step_list_prefix_matcher_core NOT OK");
        end
        $finish;
    end

endmodule
